@@ sv/assert_macros.svh @@
// Assertion macros for the checker file.
// Depends on nothing; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that also runs while reset is asserted
`define ASSERT_CLK(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("check failed");

// Concurrent check that is switched off while the active-low reset is low
`define ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("check failed");

`endif

@@ sv/sfd_pkg.sv @@
// Types and constants of the sensor frame deframer.
// No dependencies; used by the top level and its checker.
package sfd_pkg;

    // Kind of an input word, carried on s_tuser
    typedef enum logic [0:0] {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } sfd_op_t;

    // Result status, carried on m_tuser
    typedef enum logic [1:0] {
        ST_GOOD    = 2'd0,
        ST_BADSUM  = 2'd1,
        ST_TIMEOUT = 2'd2
    } sfd_status_t;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CONC_W    = 16;
    localparam int unsigned TICK_W    = 16;
    localparam int unsigned IDX_W     = 3;

    localparam logic [BYTE_W-1:0] START_BYTE    = 8'hFF;
    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd200;
    localparam logic [TICK_W-1:0] TICK_MAX      = 16'hFFFF;

    // Byte positions after the start byte, counted from zero
    localparam logic [IDX_W-1:0] HIGH_IDX = 3'd3;  // fourth byte
    localparam logic [IDX_W-1:0] LOW_IDX  = 3'd4;  // fifth byte
    localparam logic [IDX_W-1:0] LAST_IDX = 3'd7;  // checksum byte

endpackage

@@ sv/sensor_frame_deframer.sv @@
// Sensor frame deframer: input word register, frame state and result register.
// Depends on sfd_pkg.
//
// Usage:
//   s_* channel takes one word per handshake: s_tuser is the word kind
//   (received UART byte or one millisecond tick), s_tdata the byte.
//   After a start byte 0xFF the next eight bytes form a frame; the last one
//   must be the two's complement of the sum of bytes one to seven.
//   m_* channel gives one word per finished frame: m_tuser is the status
//   (good, checksum mismatch, timed out), m_tdata the concentration in
//   hundredths of ppm (zero unless good). Most words give no result.
//   cfg_we / cfg_wdata write the frame timeout in ticks; write it while idle.
//   A word accepted on s_* waits in the input word register; when it moves on,
//   its result, if any, is written into the result register and shown on m_*.
//   Throughput: one word per cycle while no result waits on m_tready.
//   Reset: hunting for a start byte, no pending result, timeout 200 ticks.
//   Stall: while a result waits on m_tready the input register holds one more
//   word; s_tready drops only when both are full.
module sensor_frame_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic [0:0]  s_tuser,    // [0] operation
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [15:0] concentration_hundredths
    output logic [1:0]  m_tuser,    // [1:0] status
    // configuration
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata   // frame_timeout_ticks
);

    // input word register
    logic                               in_valid_reg, in_valid_next;
    sfd_pkg::sfd_op_t                   op_reg;
    logic [sfd_pkg::BYTE_W-1:0]         byte_reg;

    // frame state
    logic                               in_frame_reg, in_frame_next;
    logic [sfd_pkg::IDX_W-1:0]          taken_reg, taken_next;
    logic [sfd_pkg::BYTE_W-1:0]         sum_reg, sum_next;
    logic [sfd_pkg::BYTE_W-1:0]         conc_hi_reg, conc_hi_next;
    logic [sfd_pkg::BYTE_W-1:0]         conc_lo_reg, conc_lo_next;
    logic [sfd_pkg::TICK_W-1:0]         ticks_reg, ticks_next;
    logic [sfd_pkg::TICK_W-1:0]         timeout_reg;

    // result register
    logic                               out_valid_reg, out_valid_next;
    sfd_pkg::sfd_status_t               status_reg;
    logic [sfd_pkg::CONC_W-1:0]         conc_reg;

    // per-word result
    logic                               res_valid;
    sfd_pkg::sfd_status_t               res_status;
    logic [sfd_pkg::CONC_W-1:0]         res_conc;
    logic [sfd_pkg::TICK_W-1:0]         ticks_inc;
    logic [sfd_pkg::BYTE_W-1:0]         expect_sum;
    logic                               advance;
    logic                               s_accept;

    // the held word moves on when the result register is free or being drained
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;

    assign ticks_inc  = (ticks_reg == sfd_pkg::TICK_MAX) ? ticks_reg
                                                         : ticks_reg + 1'b1;
    assign expect_sum = ~sum_reg + 1'b1;

    // frame update for the held word
    always_comb begin
        in_frame_next = in_frame_reg;
        taken_next    = taken_reg;
        sum_next      = sum_reg;
        conc_hi_next  = conc_hi_reg;
        conc_lo_next  = conc_lo_reg;
        ticks_next    = ticks_reg;
        res_valid     = 1'b0;
        res_status    = sfd_pkg::ST_GOOD;
        res_conc      = '0;
        if (advance) begin
            if (op_reg == sfd_pkg::OP_TICK) begin
                if (in_frame_reg) begin
                    ticks_next = ticks_inc;
                    if (ticks_inc >= timeout_reg) begin
                        in_frame_next = 1'b0;
                        res_valid     = 1'b1;
                        res_status    = sfd_pkg::ST_TIMEOUT;
                    end
                end
            end else if (!in_frame_reg) begin
                // hunting: only the start byte opens a frame
                if (byte_reg == sfd_pkg::START_BYTE) begin
                    in_frame_next = 1'b1;
                    taken_next    = '0;
                    sum_next      = '0;
                    ticks_next    = '0;
                end
            end else if (taken_reg != sfd_pkg::LAST_IDX) begin
                sum_next   = sum_reg + byte_reg;
                taken_next = taken_reg + 1'b1;
                if (taken_reg == sfd_pkg::HIGH_IDX) begin
                    conc_hi_next = byte_reg;
                end
                if (taken_reg == sfd_pkg::LOW_IDX) begin
                    conc_lo_next = byte_reg;
                end
            end else begin
                // checksum byte closes the frame
                in_frame_next = 1'b0;
                res_valid     = 1'b1;
                if (byte_reg == expect_sum) begin
                    res_status = sfd_pkg::ST_GOOD;
                    res_conc   = {conc_hi_reg, conc_lo_reg};
                end else begin
                    res_status = sfd_pkg::ST_BADSUM;
                end
            end
        end
    end

    // valid flags of the two registers
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = res_valid;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            in_frame_reg  <= 1'b0;
            taken_reg     <= '0;
            sum_reg       <= '0;
            ticks_reg     <= '0;
            conc_hi_reg   <= '0;
            conc_lo_reg   <= '0;
            timeout_reg   <= sfd_pkg::TIMEOUT_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            in_frame_reg  <= in_frame_next;
            taken_reg     <= taken_next;
            sum_reg       <= sum_next;
            ticks_reg     <= ticks_next;
            conc_hi_reg   <= conc_hi_next;
            conc_lo_reg   <= conc_lo_next;
            if (cfg_we) begin
                timeout_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg   <= sfd_pkg::sfd_op_t'(s_tuser[0]);
            byte_reg <= s_tdata;
        end
        if (advance && res_valid) begin
            status_reg <= res_status;
            conc_reg   <= res_conc;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = conc_reg;
    assign m_tuser  = status_reg;

endmodule

@@ sv/sfd_checker.sv @@
// Port-level checks of the sensor frame deframer, bound to the top level.
// Depends on sfd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sfd_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic [1:0]  m_tuser
);

    logic out_stall;
    logic out_not_good;

    // result word offered but not taken
    assign out_stall    = m_tvalid && !m_tready;
    assign out_not_good = m_tvalid && (m_tuser != 2'(sfd_pkg::ST_GOOD));

    // a stalled result word holds its value
    `ASSERT_RST(a_out_hold, aclk, aresetn, out_stall |=> m_tvalid && $stable({m_tuser, m_tdata}))

    // only a good frame carries a concentration
    `ASSERT_RST(a_conc_zero, aclk, aresetn, out_not_good |-> m_tdata == 16'd0)

    // input backpressure only while a result is stuck at the output
    `ASSERT_RST(a_ready_cause, aclk, aresetn, !s_tready |-> out_stall)

    // reset leaves no result pending
    `ASSERT_CLK(a_reset_empty, aclk, !aresetn |=> !m_tvalid)

endmodule

bind sensor_frame_deframer sfd_checker u_sfd_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
);

@@ sim/tb_sensor_frame_deframer.sv @@
// Self-checking testbench for sensor_frame_deframer: bytes and ticks go in on s_*,
// frame results come back on m_* and are compared with a built-in frame predictor.
// Depends on sfd_pkg and the sensor_frame_deframer RTL.
`timescale 1ns / 100ps

module tb_sensor_frame_deframer;
    import sfd_pkg::*;

    localparam int unsigned CLK_HALF     = 2;
    localparam int unsigned RESET_CYCLES = 12;
    localparam int unsigned PHASE_WORDS  = 225;
    localparam int unsigned SETTLE       = 5;
    localparam int unsigned HOLD_CYCLES  = 200;
    localparam int unsigned RUN_LIMIT_NS = 2_400_000;

    typedef struct {
        sfd_status_t status;
        logic [15:0] conc;
    } frame_result_t;

    // Frame predictor plus the queue of results it still waits for
    class frame_scoreboard;
        logic [TICK_W-1:0] timeout_ticks;
        bit                in_frame;
        logic [IDX_W-1:0]  taken;
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] conc_hi;
        logic [BYTE_W-1:0] conc_lo;
        logic [TICK_W-1:0] ticks;
        frame_result_t     expected_q[$];
        int unsigned       errors;
        int unsigned       good_n;
        int unsigned       badsum_n;
        int unsigned       timeout_n;

        function new();
            timeout_ticks = TIMEOUT_RESET;
            clear_frame();
        endfunction

        function void clear_frame();
            in_frame = 0;
            taken    = '0;
            sum      = '0;
            conc_hi  = '0;
            conc_lo  = '0;
            ticks    = '0;
        endfunction

        // Accepted input word; returns 1 when the word was not simply dropped
        function bit note_word(sfd_op_t op, logic [BYTE_W-1:0] b);
            frame_result_t     r;
            logic [BYTE_W-1:0] want;
            bit                acted;
            acted = in_frame || (op == OP_BYTE && b == START_BYTE);
            if (op == OP_TICK) begin
                if (in_frame) begin
                    if (ticks != TICK_MAX)
                        ticks = ticks + 1'b1;
                    if (ticks >= timeout_ticks) begin
                        r.status = ST_TIMEOUT;
                        r.conc   = '0;
                        expected_q.push_back(r);
                        timeout_n++;
                        clear_frame();
                    end
                end
            end else if (!in_frame) begin
                if (b == START_BYTE) begin
                    clear_frame();
                    in_frame = 1;
                end
            end else if (taken != LAST_IDX) begin
                sum = sum + b;
                if (taken == HIGH_IDX)
                    conc_hi = b;
                else if (taken == LOW_IDX)
                    conc_lo = b;
                taken = taken + 1'b1;
            end else begin
                // checksum byte closes the frame
                want = 8'd0 - sum;
                if (want == b) begin
                    r.status = ST_GOOD;
                    r.conc   = {conc_hi, conc_lo};
                    good_n++;
                end else begin
                    r.status = ST_BADSUM;
                    r.conc   = '0;
                    badsum_n++;
                end
                expected_q.push_back(r);
                clear_frame();
            end
            return acted;
        endfunction

        function void check_result(sfd_status_t status, logic [15:0] conc);
            frame_result_t e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result, got status %0d conc 0x%04h",
                         $time, status, conc);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (status !== e.status) begin
                $display("%0t: status mismatch, expected %0d got %0d",
                         $time, e.status, status);
                errors++;
            end
            if (conc !== e.conc) begin
                $display("%0t: concentration mismatch, expected 0x%04h got 0x%04h",
                         $time, e.conc, conc);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] data_byte
    logic [0:0]  s_tuser;    // [0] operation
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;    // [15:0] concentration_hundredths
    logic [1:0]  m_tuser;    // [1:0] status
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    frame_scoreboard sb;
    int unsigned     gap_max;
    int unsigned     stall_max;
    bit              hold_req;
    int unsigned     holds_done;
    int unsigned     acted_words;
    int unsigned     dropped_words;
    int unsigned     settings_n;
    logic [15:0]     cur_timeout;

    sensor_frame_deframer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_HALF) aclk = ~aclk;

    // Run limit
    initial begin
        #(RUN_LIMIT_NS);
        $display("%0t: run limit reached", $time);
        $display("CHECKS FAILED");
        $finish;
    end

    // Result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(sfd_status_t'(m_tuser), m_tdata);
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        int unsigned n;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (hold_req) begin
                @(negedge aclk) m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 0;
                holds_done++;
            end
            n = $urandom_range(0, stall_max);
            if (n != 0) begin
                @(negedge aclk) m_tready = 1'b0;
                repeat (n - 1) @(negedge aclk);
            end
            @(negedge aclk) m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // One word on s_*, after a random gap; returns once it is accepted
    task automatic send_word(input sfd_op_t op, input logic [7:0] b);
        int unsigned gap;
        gap = $urandom_range(0, gap_max);
        if (gap != 0) begin
            @(negedge aclk) s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = b;
        do @(posedge aclk); while (!s_tready);
        if (sb.note_word(op, b))
            acted_words++;
        else
            dropped_words++;
    endtask

    task automatic send_ticks(input int unsigned n);
        repeat (n) send_word(OP_TICK, 8'($urandom));
    endtask

    // Extremes show up more often than plain random bytes would give them
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Start byte, n_payload payload bytes with ticks mixed in, checksum byte if seven
    task automatic send_frame(input bit good_sum, input int unsigned n_payload);
        logic [7:0] b;
        logic [7:0] acc;
        acc = 8'd0;
        send_word(OP_BYTE, START_BYTE);
        for (int i = 0; i < n_payload; i++) begin
            if ($urandom_range(0, 3) == 0)
                send_ticks($urandom_range(1, 2));
            b = pick_byte();
            acc = acc + b;
            send_word(OP_BYTE, b);
        end
        if (n_payload == 7) begin
            b = 8'd0 - acc;
            if (!good_sum)
                b = b ^ 8'($urandom_range(1, 255));
            send_word(OP_BYTE, b);
        end
    endtask

    task automatic write_timeout(input logic [15:0] v);
        @(negedge aclk);
        s_tvalid  = 1'b0;
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(negedge aclk) cfg_we = 1'b0;
        sb.timeout_ticks = v;
        cur_timeout = v;
        settings_n++;
    endtask

    // Wait for every expected result, then let the pipeline settle
    task automatic drain();
        @(negedge aclk) s_tvalid = 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Random mix of frames, noise and broken frames
    task automatic random_traffic(input int unsigned words);
        int unsigned stop_at;
        int unsigned n;
        stop_at = acted_words + dropped_words + words;
        while (acted_words + dropped_words < stop_at) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: send_frame(1'b1, 7);
                5: send_frame(1'b0, 7);
                6: begin
                    // noise: stray bytes and ticks
                    repeat ($urandom_range(1, 4)) begin
                        if ($urandom_range(0, 1))
                            send_word(OP_TICK, 8'($urandom));
                        else
                            send_word(OP_BYTE, pick_byte());
                    end
                end
                7: send_frame(1'b1, $urandom_range(0, 6));
                8: begin
                    // start byte, then ticks close to the timeout if it is at most 100, else a short run
                    send_word(OP_BYTE, START_BYTE);
                    if (cur_timeout <= 100)
                        n = cur_timeout + $urandom_range(0, 2);
                    else
                        n = $urandom_range(1, 60);
                    send_ticks(n - 1);
                end
                default: send_ticks($urandom_range(1, 3));
            endcase
        end
    endtask

    // Main sequence
    initial begin
        logic [15:0] settings[7];
        aclk          = 1'b0;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = OP_BYTE;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        gap_max       = 0;
        stall_max     = 0;
        hold_req      = 0;
        holds_done    = 0;
        acted_words   = 0;
        dropped_words = 0;
        settings_n    = 1;
        cur_timeout   = TIMEOUT_RESET;
        sb            = new();

        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: tick while hunting, all-zero frame, all-0xFF frame
        // (start byte inside a frame, largest concentration), bad checksum
        send_word(OP_TICK, 8'h00);
        send_word(OP_BYTE, START_BYTE);
        repeat (8) send_word(OP_BYTE, 8'h00);
        send_word(OP_BYTE, START_BYTE);
        repeat (7) send_word(OP_BYTE, 8'hFF);
        send_word(OP_BYTE, 8'h07);
        send_word(OP_BYTE, START_BYTE);
        send_word(OP_BYTE, 8'h01);
        send_word(OP_BYTE, 8'h02);
        send_word(OP_BYTE, 8'h03);
        send_word(OP_BYTE, 8'hAB);
        send_word(OP_BYTE, 8'hCD);
        send_word(OP_BYTE, 8'h06);
        send_word(OP_BYTE, 8'h07);
        send_word(OP_BYTE, 8'h55);

        // Reset timeout first, then one setting per phase
        gap_max   = 6;
        stall_max = 6;
        random_traffic(PHASE_WORDS);
        settings = '{16'd1, 16'd65535, 16'd2, 16'($urandom_range(3, 12)),
                     16'($urandom_range(13, 100)), 16'($urandom_range(101, 65535)),
                     16'd5};
        for (int p = 0; p < 7; p++) begin
            drain();
            write_timeout(settings[p]);
            case (p % 4)
                0: begin gap_max = 0; stall_max = 0; end
                1: begin gap_max = 6; stall_max = 6; end
                2: begin gap_max = 0; stall_max = 6; end
                default: begin gap_max = 6; stall_max = 0; end
            endcase
            // long receiver hold-off while the sender keeps pushing
            if (p == 2)
                hold_req = 1;
            random_traffic(PHASE_WORDS);
        end
        drain();

        $display("Covered %0d frame words and %0d dropped words over %0d timeout settings",
                 acted_words, dropped_words, settings_n);
        $display("Frames: %0d good, %0d checksum errors, %0d timeouts; %0d receiver hold-offs",
                 sb.good_n, sb.badsum_n, sb.timeout_n, holds_done);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d results never arrived",
                     sb.errors, sb.expected_q.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
